// ===== rtl/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared constants, types and helpers for the cubic bezier easing core.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // Solver iteration limits
  localparam int NEWTON_STEPS = 8;
  localparam int BISECT_STEPS = 30;

  // Datapath widths: working values, curve parameter, port values
  localparam int WW  = 48;
  localparam int SW  = 32;
  localparam int PW  = 18;
  localparam int NCW = $clog2(NEWTON_STEPS + 1);
  localparam int BCW = $clog2(BISECT_STEPS + 1);

  // Q2.30 constants
  localparam int ONE_Q30 = 1 << 30;
  localparam int EPS_Q30 = 1074;

  typedef logic signed [WW-1:0] wide_t;
  typedef logic signed [SW-1:0] sq_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_X1 = 2'd0,
    CFG_Y1 = 2'd1,
    CFG_X2 = 2'd2,
    CFG_Y2 = 2'd3
  } cfg_idx_e;

  // Magnitude of a working value
  function automatic logic [WW-1:0] mag_w(input wide_t v);
    mag_w = v[WW-1] ? $unsigned(-v) : $unsigned(v);
  endfunction

  // Strict tolerance test |v| < EPS
  function automatic logic is_small(input wide_t v);
    is_small = (v > -wide_t'(EPS_Q30)) && (v < wide_t'(EPS_Q30));
  endfunction

endpackage

// ===== rtl/cbe_in_if.sv =====
// ----------------------------------------------------------------------------
// cbe_in_if
// Progress input channel: valid/ready with one signed Q2.16 value.
// ----------------------------------------------------------------------------
interface cbe_in_if;
  logic              valid;
  logic              ready;
  logic signed [17:0] progress;

  modport source (output valid, output progress, input ready);
  modport sink   (input valid, input progress, output ready);
endinterface

// ===== rtl/cbe_out_if.sv =====
// ----------------------------------------------------------------------------
// cbe_out_if
// Eased output channel: valid/ready with one signed Q2.16 value.
// ----------------------------------------------------------------------------
interface cbe_out_if;
  logic              valid;
  logic              ready;
  logic signed [17:0] eased;

  modport source (output valid, output eased, input ready);
  modport sink   (input valid, input eased, output ready);
endinterface

// ===== rtl/cubic_bezier_easing_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_easing_core
// CSS-style cubic bezier timing function: eased = Y(s) where X(s) = progress.
// ----------------------------------------------------------------------------
// One progress value is taken at a time; the channel is not ready until the
// result is queued. Progress at or below 0 or at or above 1.0 skips the solver
// and goes straight to the result stage. Otherwise every operation runs on one
// shared 48x16 multiplier, which forms each Q2.30 product in two halves, and one
// bit-serial divider: an item takes up to 8 Newton steps and up to 30 bisection
// steps before the final Y evaluation, and then waits out any output stall.
// Configuration writes apply to the next item taken.
module cubic_bezier_easing_core import cbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  cbe_in_if.sink            in_ch,
  cbe_out_if.source         out_ch,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [PW-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_LO, ST_MUL_HI, ST_DIV, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_NX, PH_ND, PH_BX, PH_Y
  } phase_e;

  // Configuration registers
  logic [16:0]        ctrl_x1_q, ctrl_x2_q;
  logic signed [17:0] ctrl_y1_q, ctrl_y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_x1_q <= 17'd0;
      ctrl_y1_q <= 18'sd0;
      ctrl_x2_q <= 17'd65536;
      ctrl_y2_q <= 18'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X1:  ctrl_x1_q <= cfg_data_i[16:0];
        CFG_Y1:  ctrl_y1_q <= cfg_data_i;
        CFG_X2:  ctrl_x2_q <= cfg_data_i[16:0];
        CFG_Y2:  ctrl_y2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coefficients from control points, latched per transaction
  logic [16:0] x1c, x2c;
  wide_t x1w, x2w, y1w, y2w, dxw, dyw;
  wide_t cx_n, bx_n, ax_n, cy_n, by_n, ay_n, x_n;

  always_comb begin
    x1c  = (ctrl_x1_q > 17'd65536) ? 17'd65536 : ctrl_x1_q;
    x2c  = (ctrl_x2_q > 17'd65536) ? 17'd65536 : ctrl_x2_q;
    x1w  = {17'b0, x1c, 14'b0};
    x2w  = {17'b0, x2c, 14'b0};
    y1w  = {{16{ctrl_y1_q[17]}}, ctrl_y1_q, 14'b0};
    y2w  = {{16{ctrl_y2_q[17]}}, ctrl_y2_q, 14'b0};
    dxw  = x2w - x1w;
    dyw  = y2w - y1w;
    cx_n = x1w + (x1w <<< 1);
    bx_n = dxw + (dxw <<< 1) - cx_n;
    ax_n = wide_t'(ONE_Q30) - cx_n - bx_n;
    cy_n = y1w + (y1w <<< 1);
    by_n = dyw + (dyw <<< 1) - cy_n;
    ay_n = wide_t'(ONE_Q30) - cy_n - by_n;
    x_n  = {{16{in_ch.progress[17]}}, in_ch.progress, 14'b0};
  end

  // Sequencer state
  state_e          state_q;
  phase_e          phase_q;
  logic [1:0]      k_q;
  logic [NCW-1:0]  nc_q;
  logic [BCW-1:0]  bc_q;
  wide_t           acc_q, xt_q, d_q, x_q;
  wide_t           ax_q, bx_q, cx_q, ay_q, by_q, cy_q;
  sq_t             s_q;
  logic [30:0]     lo_q, hi_q;
  logic [63:0]     prod_q;
  logic [PW-1:0]   res_q;
  logic            div_start_q;
  logic            out_valid_q;
  logic [PW-1:0]   out_data_q;

  // Shared multiplier: |acc| times one 16-bit half of |s|
  logic [WW-1:0] a_mag;
  logic [SW-1:0] s_mag;
  logic [15:0]   s_half;
  logic [63:0]   pp;
  logic [79:0]   full;
  logic [WW-1:0] r_mag;
  wide_t         mul_r;

  always_comb begin
    a_mag  = mag_w(acc_q);
    s_mag  = s_q[SW-1] ? $unsigned(-s_q) : $unsigned(s_q);
    s_half = (state_q == ST_MUL_LO) ? s_mag[15:0] : s_mag[31:16];
    pp     = a_mag * s_half;
    full   = {16'b0, prod_q} + {pp, 16'b0};
    r_mag  = full[77:30];
    mul_r  = (acc_q[WW-1] ^ s_q[SW-1]) ? -$signed(r_mag) : $signed(r_mag);
  end

  // Coefficients of the polynomial under evaluation
  wide_t cur_b, cur_c;
  always_comb begin
    cur_b = (phase_q == PH_Y) ? by_q : bx_q;
    cur_c = (phase_q == PH_Y) ? cy_q : cx_q;
  end

  // Decisions taken at the end of a chain
  wide_t        diff, d_val;
  logic         x_gt;
  logic [30:0]  lo_n, hi_n;
  logic [31:0]  mid_sum;
  sq_t          mid;

  always_comb begin
    diff    = mul_r - x_q;
    d_val   = mul_r + cx_q;
    x_gt    = x_q > mul_r;
    lo_n    = x_gt ? s_q[30:0] : lo_q;
    hi_n    = x_gt ? hi_q : s_q[30:0];
    mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
    mid     = sq_t'(mid_sum >> 1);
  end

  // Divider and Newton update
  logic          div_done;
  logic [SW:0]   quot;
  logic          q_neg;
  logic signed [SW+1:0] q_s, s_sub;
  sq_t           s_newton;

  cbe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (mag_w(xt_q)),
    .den_i   (mag_w(d_q)),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    q_neg = xt_q[WW-1] ^ d_q[WW-1];
    q_s   = q_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    s_sub = {{2{s_q[SW-1]}}, s_q} - q_s;
    if (s_sub[SW+1:SW-1] == 3'b000 || s_sub[SW+1:SW-1] == 3'b111) begin
      s_newton = s_sub[SW-1:0];
    end else begin
      s_newton = s_sub[SW+1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
  end

  // Rounding Q2.30 -> Q2.16, half away from zero, saturated
  logic [WW:0]   y_sum;
  logic [34:0]   uy;
  logic [PW-1:0] uy_c, y_res;

  always_comb begin
    y_sum = {1'b0, mag_w(mul_r)} + (WW+1)'(8192);
    uy    = y_sum[WW:14];
    uy_c  = (uy > 35'd131072) ? 18'd131072 : uy[PW-1:0];
    if (mul_r[WW-1]) begin
      y_res = -uy_c;
    end else begin
      y_res = (uy_c == 18'd131072) ? 18'd131071 : uy_c;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_NX;
      k_q         <= '0;
      nc_q        <= '0;
      bc_q        <= '0;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_ch.valid) begin
            ax_q <= ax_n; bx_q <= bx_n; cx_q <= cx_n;
            ay_q <= ay_n; by_q <= by_n; cy_q <= cy_n;
            x_q  <= x_n;
            s_q  <= x_n[SW-1:0];
            acc_q   <= ax_n;
            k_q     <= '0;
            nc_q    <= '0;
            phase_q <= PH_NX;
            if (in_ch.progress <= 18'sd0) begin
              res_q   <= '0;
              state_q <= ST_FIN;
            end else if (in_ch.progress >= 18'sd65536) begin
              res_q   <= 18'd65536;
              state_q <= ST_FIN;
            end else begin
              state_q <= ST_MUL_LO;
            end
          end
        end

        ST_MUL_LO: begin
          prod_q  <= pp;
          state_q <= ST_MUL_HI;
        end

        ST_MUL_HI: begin
          state_q <= ST_MUL_LO;
          k_q     <= k_q + 2'd1;
          if (phase_q == PH_ND) begin
            if (k_q == 2'd0) begin
              acc_q <= mul_r + (bx_q <<< 1);
            end else if (is_small(d_val)) begin
              // Flat derivative: fall back to bisection
              s_q <= x_q[SW-1:0]; lo_q <= '0; hi_q <= 31'(ONE_Q30);
              bc_q <= '0; phase_q <= PH_BX; acc_q <= ax_q; k_q <= '0;
            end else begin
              d_q         <= d_val;
              div_start_q <= 1'b1;
              state_q     <= ST_DIV;
            end
          end else if (k_q == 2'd0) begin
            acc_q <= mul_r + cur_b;
          end else if (k_q == 2'd1) begin
            acc_q <= mul_r + cur_c;
          end else begin
            k_q <= '0;
            case (phase_q)
              PH_NX: begin
                if (is_small(diff)) begin
                  phase_q <= PH_Y; acc_q <= ay_q;
                end else begin
                  xt_q <= diff; phase_q <= PH_ND;
                  acc_q <= ax_q + (ax_q <<< 1);
                end
              end
              PH_BX: begin
                if (is_small(diff)) begin
                  phase_q <= PH_Y; acc_q <= ay_q;
                end else begin
                  lo_q <= lo_n; hi_q <= hi_n; s_q <= mid;
                  bc_q <= bc_q + BCW'(1);
                  if (bc_q != BCW'(BISECT_STEPS - 1) && lo_n < hi_n) begin
                    acc_q <= ax_q;
                  end else begin
                    phase_q <= PH_Y; acc_q <= ay_q;
                  end
                end
              end
              default: begin
                res_q   <= y_res;
                state_q <= ST_FIN;
              end
            endcase
          end
        end

        ST_DIV: begin
          if (div_done) begin
            nc_q    <= nc_q + NCW'(1);
            k_q     <= '0;
            acc_q   <= ax_q;
            state_q <= ST_MUL_LO;
            if (nc_q == NCW'(NEWTON_STEPS - 1)) begin
              // Newton did not converge: bisection from s = t
              s_q <= x_q[SW-1:0]; lo_q <= '0; hi_q <= 31'(ONE_Q30);
              bc_q <= '0; phase_q <= PH_BX;
            end else begin
              s_q <= s_newton; phase_q <= PH_NX;
            end
          end
        end

        ST_FIN: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state_q == ST_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.eased = out_data_q;

`ifndef SYNTHESIS
  // A taken transaction always leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> state_q != ST_IDLE)
    else $error("accepted transaction left sequencer idle");

  // Bisection keeps s inside [0, 1.0]
  a_bisect_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BX && state_q == ST_MUL_LO) |-> (s_q >= 0 && s_q <= sq_t'(ONE_Q30)))
    else $error("bisection parameter out of range");

  // Newton step count stays bounded
  a_newton_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nc_q <= NCW'(NEWTON_STEPS))
    else $error("Newton step count overrun");

  // A queued result is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_valid_q && !out_ch.ready) |=> state_q == ST_FIN)
    else $error("result slot overwritten");
`endif

endmodule

// ===== rtl/cbe_div.sv =====
// ----------------------------------------------------------------------------
// cbe_div
// Radix-2 restoring divider: unsigned num/den in Q2.30, one quotient bit per
// cycle, result limited to 4.0.
// ----------------------------------------------------------------------------
module cbe_div import cbe_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [WW-1:0] num_i,
  input  logic [WW-1:0] den_i,
  output logic          done_o,
  output logic [SW:0]   quot_o
);

  logic          busy_q;
  logic          done_q;
  logic [4:0]    cnt_q;
  logic [WW:0]   rem_q;
  logic [WW-1:0] den_q;
  logic [1:0]    nlo_q;
  logic [SW:0]   quot_q;

  logic          in_bit;
  logic [WW:0]   shifted;
  logic          ge;
  logic          over;

  // Quotient would reach 4.0 or more
  assign over = {2'b00, num_i} >= {den_i, 2'b00};

  // Dividend bits below the initial remainder: two numerator LSBs, then zeros
  always_comb begin
    case (cnt_q)
      5'd31:   in_bit = nlo_q[1];
      5'd30:   in_bit = nlo_q[0];
      default: in_bit = 1'b0;
    endcase
  end

  assign shifted = {rem_q[WW-1:0], in_bit};
  assign ge      = shifted >= {1'b0, den_q};

  // Iteration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      nlo_q  <= '0;
      den_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (!over) begin
          busy_q <= 1'b1;
          cnt_q  <= 5'd31;
          quot_q <= '0;
        end
        rem_q <= {3'b000, num_i[WW-1:2]};
        nlo_q <= num_i[1:0];
        den_q <= den_i;
      end else if (busy_q) begin
        rem_q  <= ge ? (shifted - {1'b0, den_q}) : shifted;
        quot_q <= {quot_q[SW-1:0], ge};
        cnt_q  <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Saturated result: 4.0 in Q2.30
  logic sat_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (start_i) begin
      sat_q <= over;
    end else if (done_o) begin
      sat_q <= 1'b0;
    end
  end

  logic sat_done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_done_q <= 1'b0;
    end else begin
      sat_done_q <= start_i && over;
    end
  end

  assign done_o = done_q || sat_done_q;
  assign quot_o = sat_q ? {1'b1, {SW{1'b0}}} : quot_q;

endmodule
